[rtl/mlet_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlet_pkg
// Shared types and fixed field widths of the leading-edge trigger.
// ----------------------------------------------------------------------------
package mlet_pkg;

    localparam int NUM_CH    = 6;   // paddles A..E, then beam monitor
    localparam int NUM_PAD   = 5;
    localparam int SAMPLE_W  = 14;
    localparam int TICK_W    = 12;
    localparam int COUNT_W   = 3;
    localparam int IN_DATA_W = 88;  // 84 payload bits, zero-filled to bytes
    localparam int OUT_DATA_W = 24; // 21 payload bits, zero-filled to bytes

    localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 14'd8000;

    // Per-request control from the top level to the merge stage
    typedef struct packed {
        logic accept;
        logic start;
        logic last;
    } ctl_t;

    // One result item
    typedef struct packed {
        logic               count_valid;
        logic [COUNT_W-1:0] paddle_count;
        logic [TICK_W-1:0]  edge_tick;
        logic [NUM_CH-1:0]  edge_mask;
    } result_t;

endpackage

[rtl/mlet_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlet_lane
// Edge discriminator of one channel: hysteresis flag and leading-edge flag.
// ----------------------------------------------------------------------------
module mlet_lane #(
    parameter int CMP_W = 14
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic             start,
    input  logic [CMP_W-1:0] sample,
    input  logic [CMP_W-1:0] threshold,
    output logic             edge_hit
);

    logic below_reg;
    logic below_next;
    logic is_below;
    logic is_above;

    assign is_below = sample < threshold;
    assign is_above = sample > threshold;

    // A waveform start loads the flag without reporting
    assign edge_hit = !start && !below_reg && is_below;

    always_comb
    begin
        priority if (start)
        begin
            below_next = is_below;
        end
        else if (below_reg)
        begin
            below_next = !is_above;
        end
        else
        begin
            below_next = is_below;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            below_reg <= 1'b0;
        end
        else if (accept)
        begin
            below_reg <= below_next;
        end
    end

endmodule

[rtl/mlet_merge.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlet_merge
// Combines lane edges: tick counter, paddle hit flags, coincidence count,
// and a two-entry output stage (output register plus skid register).
// ----------------------------------------------------------------------------
module mlet_merge #(
    parameter int WAVE_MAX = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mlet_pkg::ctl_t                ctl,
    input  logic [mlet_pkg::NUM_CH-1:0]   edges,
    output logic                          in_ready,
    output logic                          out_valid,
    input  logic                          out_ready,
    output mlet_pkg::result_t             out_result
);

    localparam int TOP_INT = (WAVE_MAX - 1 < 4095) ? (WAVE_MAX - 1) : 4095;
    localparam logic [mlet_pkg::TICK_W-1:0] TICK_TOP = mlet_pkg::TICK_W'(TOP_INT);

    logic [mlet_pkg::TICK_W-1:0]   tick_reg;
    logic [mlet_pkg::TICK_W-1:0]   tick_next;
    logic [mlet_pkg::NUM_PAD-1:0]  hit_reg;
    logic [mlet_pkg::NUM_PAD-1:0]  hit_next;
    logic [mlet_pkg::NUM_PAD-1:0]  hit_all;
    logic [mlet_pkg::COUNT_W-1:0]  count;
    mlet_pkg::result_t             result;
    mlet_pkg::result_t             out_reg;
    mlet_pkg::result_t             skid_reg;
    logic                          out_valid_reg;
    logic                          skid_valid_reg;
    logic                          take;

    always_comb
    begin
        priority if (ctl.start)
        begin
            tick_next = '0;
        end
        else if (tick_reg < TICK_TOP)
        begin
            tick_next = tick_reg + mlet_pkg::TICK_W'(1);
        end
        else
        begin
            tick_next = tick_reg;
        end
    end

    // Lane edges are already zero on a start slice
    assign hit_all = hit_reg | edges[mlet_pkg::NUM_PAD-1:0];
    assign hit_next = ctl.last ? '0 : hit_all;

    always_comb
    begin
        count = '0;
        for (int i = 0; i < mlet_pkg::NUM_PAD; i++)
        begin
            count = count + mlet_pkg::COUNT_W'(hit_all[i]);
        end
    end

    always_comb
    begin
        result.edge_mask    = edges;
        result.edge_tick    = tick_next;
        result.paddle_count = ctl.last ? count : '0;
        result.count_valid  = ctl.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg <= '0;
            hit_reg  <= '0;
        end
        else if (ctl.accept)
        begin
            tick_reg <= tick_next;
            hit_reg  <= hit_next;
        end
    end

    // Output stage: a new request goes to the output register when it is free
    // or drains this cycle, otherwise it parks in the skid register.
    assign take      = out_valid_reg && out_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_result = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (ctl.accept)
        begin
            if (!out_valid_reg || take)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_reg  <= skid_valid_reg;
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            if (!out_valid_reg || take)
            begin
                out_reg <= result;
            end
            else
            begin
                skid_reg <= result;
            end
        end
        else if (take && skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
    end

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a request while output register is empty");

    a_tick_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tick_reg <= TICK_TOP)
        else $error("tick counter beyond its top");

    a_start_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.accept && ctl.start) |=> (tick_reg == '0))
        else $error("tick did not restart on waveform start");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.accept && ctl.last) |=> (hit_reg == '0))
        else $error("paddle hits not cleared at event end");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.paddle_count <= mlet_pkg::COUNT_W'(mlet_pkg::NUM_PAD)))
        else $error("paddle count out of range");

endmodule

[rtl/multi_channel_leading_edge_trigger.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_channel_leading_edge_trigger
// Leading-edge discriminator on six digitizer channels with paddle
// coincidence count at the end of each event.
// ----------------------------------------------------------------------------
// The block takes one time slice (five paddles and the beam monitor) every
// clock while s_tready is high and returns exactly one result per slice. Six
// comparator lanes work on the slice in parallel and a merge stage forms the
// edge mask, tick and paddle count in the same cycle; the result is registered
// in the output or skid register before it reaches the master side. A two-entry
// output stage lets a slice be taken while the previous result still waits;
// s_tready drops only when both entries are full. The threshold may be written
// only while the block is idle.
// ----------------------------------------------------------------------------
module multi_channel_leading_edge_trigger #(
    parameter int SAMPLE_BITS = 14,
    parameter int WAVE_MAX    = 4096
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               threshold_wr_en,
    input  logic [mlet_pkg::SAMPLE_W-1:0]      threshold_wr_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // sample_a, sample_b, sample_c, sample_d, sample_e, sample_monitor, zero fill
    input  logic [mlet_pkg::IN_DATA_W-1:0]     s_tdata,
    // waveform_start
    input  logic                               s_tuser,
    // event_end
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // edge_mask, edge_tick, paddle_count, zero fill
    output logic [mlet_pkg::OUT_DATA_W-1:0]    m_tdata,
    // count_valid
    output logic                               m_tlast
);

    localparam int CMP_W = (SAMPLE_BITS < mlet_pkg::SAMPLE_W) ? SAMPLE_BITS
                                                               : mlet_pkg::SAMPLE_W;

    logic [mlet_pkg::SAMPLE_W-1:0] threshold_reg;
    logic [mlet_pkg::NUM_CH-1:0]   edges;
    mlet_pkg::ctl_t                ctl;
    mlet_pkg::result_t             result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= mlet_pkg::THRESHOLD_RESET;
        end
        else if (threshold_wr_en)
        begin
            threshold_reg <= threshold_wr_data;
        end
    end

    assign ctl.accept = s_tvalid && s_tready;
    assign ctl.start  = s_tuser;
    assign ctl.last   = s_tlast;

    for (genvar ch = 0; ch < mlet_pkg::NUM_CH; ch++)
    begin : g_lane
        mlet_lane #(
            .CMP_W (CMP_W)
        ) u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .accept    (ctl.accept),
            .start     (ctl.start),
            .sample    (s_tdata[ch*mlet_pkg::SAMPLE_W +: CMP_W]),
            .threshold (threshold_reg[CMP_W-1:0]),
            .edge_hit  (edges[ch])
        );
    end

    mlet_merge #(
        .WAVE_MAX (WAVE_MAX)
    ) u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .edges      (edges),
        .in_ready   (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    assign m_tdata = {3'b000, result.paddle_count, result.edge_tick, result.edge_mask};
    assign m_tlast = result.count_valid;

endmodule
